>>> hw/rtl/vge_pkg.sv
package vge_pkg;

  localparam int ALLELE_WIDTH       = 16;
  localparam int SAMPLE_COUNT_WIDTH = 20;
  localparam int QUEUE_DEPTH        = 4;
  localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
  localparam int POS_W              = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_GENOTYPE   = 2'd0;
  localparam logic [1:0] ST_NO_FORMAT  = 2'd1;
  localparam logic [1:0] ST_NO_SAMPLES = 2'd2;

  localparam logic [POS_W-1:0] POS_START = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);

  typedef enum logic [3:0] {
    CC_TAB,
    CC_COLON,
    CC_DOT,
    CC_SLASH,
    CC_BAR,
    CC_G,
    CC_T,
    CC_DIGIT,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        line_end;
  } token_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_FMT_CHECK,
    PH_FMT_SKIP,
    PH_FMT_REST,
    PH_SAMPLE_GT,
    PH_SAMPLE_REST
  } phase_t;

  typedef struct packed {
    logic sep;
    logic slash;
    logic dot;
    logic stop;
  } part_flags_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> hw/rtl/vge_if.sv
interface vge_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, text_byte, line_end, input ready);
  modport sink (input valid, text_byte, line_end, output ready);
endinterface

interface vge_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [vge_pkg::SAMPLE_COUNT_WIDTH-1:0]  sample_number;
  logic [vge_pkg::ALLELE_WIDTH-1:0]        first_allele;
  logic [vge_pkg::ALLELE_WIDTH-1:0]        second_allele;
  logic                                    is_phased;
  logic [1:0]                              status;
  logic                                    last_of_line;

  modport source (output valid, sample_number, first_allele, second_allele, is_phased,
                  status, last_of_line, input ready);
  modport sink (input valid, sample_number, first_allele, second_allele, is_phased,
                status, last_of_line, output ready);
endinterface

>>> hw/rtl/vge_front.sv
module vge_front (
  vge_in_if.sink              in_if,
  input  vge_pkg::queue_stat_t q_stat,
  output logic                q_push,
  output vge_pkg::token_t     q_tok
);

  logic [7:0] c;

  assign c           = in_if.text_byte;
  assign in_if.ready = !q_stat.full;
  assign q_push      = in_if.valid && !q_stat.full;

  always_comb begin
    q_tok.line_end = in_if.line_end;
    q_tok.digit    = 4'(c - vge_pkg::CH_ZERO);
    priority if (c == vge_pkg::CH_TAB) begin
      q_tok.cls = vge_pkg::CC_TAB;
    end else if (c == vge_pkg::CH_COLON) begin
      q_tok.cls = vge_pkg::CC_COLON;
    end else if (c == vge_pkg::CH_DOT) begin
      q_tok.cls = vge_pkg::CC_DOT;
    end else if (c == vge_pkg::CH_SLASH) begin
      q_tok.cls = vge_pkg::CC_SLASH;
    end else if (c == vge_pkg::CH_BAR) begin
      q_tok.cls = vge_pkg::CC_BAR;
    end else if (c == vge_pkg::CH_G) begin
      q_tok.cls = vge_pkg::CC_G;
    end else if (c == vge_pkg::CH_T) begin
      q_tok.cls = vge_pkg::CC_T;
    end else if (c >= vge_pkg::CH_ZERO && c <= vge_pkg::CH_NINE) begin
      q_tok.cls = vge_pkg::CC_DIGIT;
    end else begin
      q_tok.cls = vge_pkg::CC_OTHER;
    end
  end

endmodule

>>> hw/rtl/vge_queue.sv
module vge_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  vge_pkg::token_t      din,
  input  logic                 pop,
  output vge_pkg::token_t      dout,
  output vge_pkg::queue_stat_t stat
);

  vge_pkg::token_t             mem_r [vge_pkg::QUEUE_DEPTH];
  logic [vge_pkg::QPTR_W:0]    wr_ptr_r;
  logic [vge_pkg::QPTR_W:0]    rd_ptr_r;

  assign stat.empty = (wr_ptr_r == rd_ptr_r);
  assign stat.full  = (wr_ptr_r[vge_pkg::QPTR_W] != rd_ptr_r[vge_pkg::QPTR_W]) &&
                      (wr_ptr_r[vge_pkg::QPTR_W-1:0] == rd_ptr_r[vge_pkg::QPTR_W-1:0]);
  assign dout       = mem_r[rd_ptr_r[vge_pkg::QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[vge_pkg::QPTR_W-1:0]] <= din;
    end
  end

endmodule

>>> hw/rtl/vge_back.sv
module vge_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vge_pkg::token_t      tok,
  input  vge_pkg::queue_stat_t q_stat,
  output logic                 pop,
  vge_out_if.source            out_if
);

  localparam int AW = vge_pkg::ALLELE_WIDTH;
  localparam int CW = vge_pkg::SAMPLE_COUNT_WIDTH;

  vge_pkg::phase_t      phase_r, phase_step, phase_nxt;
  logic [vge_pkg::POS_W-1:0] pos_r, pos_step, pos_nxt, ab_pos;
  logic [AW-1:0]        acc_r, acc_nxt, ab_acc;
  logic [AW-1:0]        held_r, held_nxt, ab_held;
  vge_pkg::part_flags_t flags_r, flags_nxt, ab_flags;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 entered, emit_sample;
  logic [AW+3:0]        acc_ext, prod;

  logic                 g_sep, g_slash, g_dot;
  logic [vge_pkg::POS_W-1:0] g_pos;
  logic [AW-1:0]        g_acc, g_held;
  logic                 absorb;

  logic                 out_valid_r;
  logic [CW-1:0]        num_r, num_nxt;
  logic [AW-1:0]        a1_r, a1_nxt, a2_r, a2_nxt;
  logic                 ph_r, ph_nxt, last_r, last_nxt;
  logic [1:0]           st_r, st_nxt;
  logic                 res_valid;

  assign pop = !q_stat.empty && (!out_valid_r || out_if.ready);

  // next phase
  always_comb begin
    phase_step  = phase_r;
    entered     = 1'b0;
    emit_sample = 1'b0;
    unique case (phase_r)
      vge_pkg::PH_FIRST: begin
        if (tok.cls == vge_pkg::CC_TAB) phase_step = vge_pkg::PH_FMT_CHECK;
      end
      vge_pkg::PH_FMT_CHECK: begin
        if (tok.cls == vge_pkg::CC_TAB) begin
          if (pos_r == vge_pkg::POS_TWO) begin
            phase_step = vge_pkg::PH_SAMPLE_GT;
            entered    = 1'b1;
          end
        end else if (pos_r == vge_pkg::POS_START && tok.cls == vge_pkg::CC_G) begin
          phase_step = vge_pkg::PH_FMT_CHECK;
        end else if (pos_r == vge_pkg::POS_ONE && tok.cls == vge_pkg::CC_T) begin
          phase_step = vge_pkg::PH_FMT_CHECK;
        end else if (pos_r == vge_pkg::POS_TWO && tok.cls == vge_pkg::CC_COLON) begin
          phase_step = vge_pkg::PH_FMT_REST;
        end else begin
          phase_step = vge_pkg::PH_FMT_SKIP;
        end
      end
      vge_pkg::PH_FMT_SKIP: begin
        if (tok.cls == vge_pkg::CC_TAB) phase_step = vge_pkg::PH_FMT_CHECK;
      end
      vge_pkg::PH_FMT_REST: begin
        if (tok.cls == vge_pkg::CC_TAB) begin
          phase_step = vge_pkg::PH_SAMPLE_GT;
          entered    = 1'b1;
        end
      end
      vge_pkg::PH_SAMPLE_GT, vge_pkg::PH_SAMPLE_REST: begin
        if (phase_r == vge_pkg::PH_SAMPLE_GT && tok.cls == vge_pkg::CC_COLON) begin
          phase_step = vge_pkg::PH_SAMPLE_REST;
        end
        if (tok.cls == vge_pkg::CC_TAB || tok.line_end) begin
          emit_sample = 1'b1;
          phase_step  = vge_pkg::PH_SAMPLE_GT;
        end
      end
      default: phase_step = vge_pkg::PH_FIRST;
    endcase
    phase_nxt = tok.line_end ? vge_pkg::PH_FIRST : phase_step;
  end

  // genotype byte: x10 accumulate with saturation
  assign acc_ext = {4'b0, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{AW{1'b0}}, tok.digit};

  always_comb begin
    ab_flags = flags_r;
    ab_pos   = pos_r;
    ab_acc   = acc_r;
    ab_held  = held_r;
    if (pos_r == vge_pkg::POS_START && tok.cls == vge_pkg::CC_DOT) ab_flags.dot = 1'b1;
    if (pos_r != vge_pkg::POS_TWO) ab_pos = pos_r + 1'b1;
    if (tok.cls == vge_pkg::CC_SLASH) ab_flags.slash = 1'b1;
    if (!flags_r.sep && (tok.cls == vge_pkg::CC_SLASH || tok.cls == vge_pkg::CC_BAR)) begin
      ab_flags.sep  = 1'b1;
      ab_flags.stop = 1'b0;
      ab_held       = acc_r;
      ab_acc        = '0;
    end else if (tok.cls == vge_pkg::CC_DIGIT && !flags_r.stop) begin
      ab_acc = (prod > {4'b0, {AW{1'b1}}}) ? {AW{1'b1}} : prod[AW-1:0];
    end else begin
      ab_flags.stop = 1'b1;
    end
  end

  assign absorb = (phase_r == vge_pkg::PH_SAMPLE_GT) && tok.cls != vge_pkg::CC_TAB &&
                  tok.cls != vge_pkg::CC_COLON;
  assign g_pos   = absorb ? ab_pos         : pos_r;
  assign g_acc   = absorb ? ab_acc         : acc_r;
  assign g_held  = absorb ? ab_held        : held_r;
  assign g_sep   = absorb ? ab_flags.sep   : flags_r.sep;
  assign g_slash = absorb ? ab_flags.slash : flags_r.slash;
  assign g_dot   = absorb ? ab_flags.dot   : flags_r.dot;

  // datapath and result
  always_comb begin
    pos_step  = pos_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    num_nxt   = '0;
    a1_nxt    = '0;
    a2_nxt    = '0;
    ph_nxt    = 1'b0;
    st_nxt    = vge_pkg::ST_GENOTYPE;
    last_nxt  = tok.line_end;
    res_valid = 1'b0;
    unique case (phase_r)
      vge_pkg::PH_FIRST, vge_pkg::PH_FMT_SKIP: begin
        if (tok.cls == vge_pkg::CC_TAB) pos_step = vge_pkg::POS_START;
      end
      vge_pkg::PH_FMT_CHECK: begin
        if (tok.cls == vge_pkg::CC_TAB) begin
          pos_step = vge_pkg::POS_START;
          if (pos_r == vge_pkg::POS_TWO) begin
            acc_nxt   = '0;
            held_nxt  = '0;
            flags_nxt = '0;
          end
        end else if (pos_r == vge_pkg::POS_START && tok.cls == vge_pkg::CC_G) begin
          pos_step = vge_pkg::POS_ONE;
        end else if (pos_r == vge_pkg::POS_ONE && tok.cls == vge_pkg::CC_T) begin
          pos_step = vge_pkg::POS_TWO;
        end
      end
      vge_pkg::PH_FMT_REST: begin
        if (tok.cls == vge_pkg::CC_TAB) begin
          pos_step  = vge_pkg::POS_START;
          acc_nxt   = '0;
          held_nxt  = '0;
          flags_nxt = '0;
        end
      end
      vge_pkg::PH_SAMPLE_GT, vge_pkg::PH_SAMPLE_REST: begin
        if (absorb) begin
          pos_step  = ab_pos;
          acc_nxt   = ab_acc;
          held_nxt  = ab_held;
          flags_nxt = ab_flags;
        end
        if (emit_sample) begin
          res_valid = 1'b1;
          num_nxt   = cnt_r;
          if (g_pos == vge_pkg::POS_ONE && g_dot) begin
            ph_nxt = 1'b1;
          end else begin
            a1_nxt = g_sep ? g_held : g_acc;
            a2_nxt = g_sep ? g_acc : a1_nxt;
            ph_nxt = !g_slash || (a1_nxt == a2_nxt);
          end
          if (cnt_r != {CW{1'b1}}) cnt_nxt = cnt_r + 1'b1;
          pos_step  = vge_pkg::POS_START;
          acc_nxt   = '0;
          held_nxt  = '0;
          flags_nxt = '0;
        end
      end
      default: ;
    endcase
    pos_nxt = pos_step;
    if (tok.line_end) begin
      if (!emit_sample) begin
        res_valid = 1'b1;
        if (entered || phase_step == vge_pkg::PH_FMT_REST ||
            (phase_step == vge_pkg::PH_FMT_CHECK && pos_step == vge_pkg::POS_TWO)) begin
          st_nxt = vge_pkg::ST_NO_SAMPLES;
        end else begin
          st_nxt = vge_pkg::ST_NO_FORMAT;
        end
      end
      pos_nxt   = vge_pkg::POS_START;
      acc_nxt   = '0;
      held_nxt  = '0;
      flags_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= vge_pkg::PH_FIRST;
      pos_r       <= vge_pkg::POS_START;
      acc_r       <= '0;
      held_r      <= '0;
      flags_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        acc_r   <= acc_nxt;
        held_r  <= held_nxt;
        flags_r <= flags_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (pop) begin
        out_valid_r <= res_valid;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      num_r  <= num_nxt;
      a1_r   <= a1_nxt;
      a2_r   <= a2_nxt;
      ph_r   <= ph_nxt;
      st_r   <= st_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.sample_number = num_r;
  assign out_if.first_allele  = a1_r;
  assign out_if.second_allele = a2_r;
  assign out_if.is_phased     = ph_r;
  assign out_if.status        = st_r;
  assign out_if.last_of_line  = last_r;

endmodule

>>> hw/rtl/vcf_genotype_extractor.sv
// VCF genotype extractor.
// in_if: one byte of a tab-separated VCF data line per request, with line_end
//   marking the last byte. The first field is skipped, the first field that is
//   "GT" or starts with "GT:" is the format field, every later field a sample.
// out_if: one genotype per sample (sample_number, alleles, is_phased), status
//   zero; the result caused by the line_end byte has last_of_line set. A line
//   without GT field or without samples gives a single error result (status
//   1 or 2, other fields zero, last_of_line set).
// Throughput: one byte per cycle while out_if.ready is high; the back end
//   parser handles one byte each cycle, including the x10 digit accumulate.
// A byte is first written into the byte queue; the parser then reads it and
//   the result it causes is registered in the result register.
// Stall: a valid result holds while out_if.ready is low; the four-entry
//   byte queue keeps accepting until it fills, then in_if.ready drops.
// Reset (synchronous, rst_n low): queue emptied, result dropped, parser back
//   at the first field of a line with a sample count of zero.
module vcf_genotype_extractor (
  input  logic      clk,
  input  logic      rst_n,
  vge_in_if.sink    in_if,
  vge_out_if.source out_if
);

  vge_pkg::queue_stat_t q_stat;
  vge_pkg::token_t      q_din;
  vge_pkg::token_t      q_dout;
  logic                 q_push;
  logic                 q_pop;

  vge_front u_front (
    .in_if  (in_if),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_tok  (q_din)
  );

  vge_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  vge_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok    (q_dout),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_if (out_if)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("byte queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("byte queue read while empty");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != vge_pkg::ST_GENOTYPE) |->
      (out_if.last_of_line && out_if.sample_number == '0 &&
       out_if.first_allele == '0 && out_if.second_allele == '0 && !out_if.is_phased))
    else $error("error result with nonzero payload");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (q_stat.empty && !out_if.valid))
    else $error("state not cleared by reset");

endmodule
